// ===== rtl/core/mqdef_pkg.sv =====
// ----------------------------------------------------------------------------
// mqdef_pkg
// Shared types and constants for the multi-queue deduplicating event FIFO.
// ----------------------------------------------------------------------------
package mqdef_pkg;

  // Default sizing
  localparam int unsigned NumQueuesDef  = 4;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned EventWidthDef = 32;

  // Fixed field widths
  localparam int unsigned MaxQueues = 4;   // width of the present mask
  localparam int unsigned QidxW     = 2;
  localparam int unsigned LimitW    = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 5;
  localparam int unsigned PresW     = 3;

  localparam logic [LimitW-1:0] LimitReset = 5'd16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESENT_MASK = 3'd0,
    REG_LIMIT_Q0     = 3'd1,
    REG_LIMIT_Q1     = 3'd2,
    REG_LIMIT_Q2     = 3'd3,
    REG_LIMIT_Q3     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_SIZE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_NOQ   = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_WRITE,
    S_NEXT,
    S_POP_RD,
    S_POP_DATA,
    S_DONE
  } state_e;

  // Operation handed to the engine
  typedef struct packed {
    func_e            func;
    logic [QidxW-1:0] qidx;
    logic             bcast;
  } mqdef_req_t;

  // Engine status back to the top level
  typedef struct packed {
    logic    idle;
    logic    done;
    status_e status;
  } mqdef_resp_t;

endpackage

// ===== rtl/core/mqdef_engine.sv =====
// ----------------------------------------------------------------------------
// mqdef_engine
// Sequencer, entry memory and per-queue pointers. One shared slot-address
// adder serves the duplicate scan, the append and the pop; one identifier
// comparator serves the duplicate scan.
// ----------------------------------------------------------------------------
module mqdef_engine import mqdef_pkg::*; #(
  parameter int unsigned NUM_QUEUES  = NumQueuesDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned EVENT_WIDTH = EventWidthDef,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  mqdef_req_t                          req_i,
  input  logic [EVENT_WIDTH-1:0]              event_i,
  input  logic [MaxQueues-1:0]                mask_i,
  input  logic [MaxQueues-1:0][LimitW-1:0]    limit_i,
  input  logic [MaxQueues-1:0]                clr_i,
  input  logic                                ack_i,
  output mqdef_resp_t                         resp_o,
  output logic [EVENT_WIDTH-1:0]              event_o,
  output logic [CW-1:0]                       count_o
);

  localparam int unsigned NQE = (NUM_QUEUES < MaxQueues) ? NUM_QUEUES : MaxQueues;
  localparam int unsigned QW  = (NQE > 1) ? $clog2(NQE) : 1;
  localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned MD  = NQE * QUEUE_DEPTH;
  localparam int unsigned AW  = $clog2(MD);
  localparam int unsigned LW  = (CW > LimitW) ? CW : LimitW;

  state_e st_q, st_d;

  // Per-queue pointers
  logic [PW-1:0] head_q [NQE];
  logic [CW-1:0] cnt_q  [NQE];

  // Item registers
  func_e            func_q;
  logic [QidxW-1:0] qidx_q;
  logic             bcast_q;
  logic [EVENT_WIDTH-1:0] ev_q;
  logic [EVENT_WIDTH-1:0] evo_q;
  status_e          status_q, status_d;
  logic [QidxW-1:0] cur_q;
  logic [CW-1:0]    idx_q;
  logic             rdv_q;

  // Entry memory
  logic [EVENT_WIDTH-1:0] mem [MD];
  logic [EVENT_WIDTH-1:0] rd_data_q;

  logic [QW-1:0] cur_ix;
  logic          cur_pres;
  logic          is_bcast;
  logic [CW-1:0] n;
  logic [PW-1:0] h;
  logic [PW-1:0] h_inc;
  logic [LW-1:0] lim_raw;
  logic [LW-1:0] lim_eff;
  logic          at_limit;
  logic          hit;
  logic [CW-1:0] off;
  logic [PW:0]   slot_sum;
  logic [PW-1:0] slot;
  logic [AW-1:0] addr;
  logic          rd_en;
  logic          wr_en;

  function automatic logic pres(input logic [QidxW-1:0] q, input logic [MaxQueues-1:0] m);
    return (int'(q) < int'(NUM_QUEUES)) && m[q];
  endfunction

  // Current queue view
  assign cur_ix   = cur_q[QW-1:0];
  assign cur_pres = pres(cur_q, mask_i);
  assign is_bcast = (func_q == FUNC_PUSH) && bcast_q;
  assign n        = cnt_q[cur_ix];
  assign h        = head_q[cur_ix];
  assign h_inc    = (h == PW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;

  // Clamp the limit to 1..QUEUE_DEPTH
  always_comb begin
    lim_raw = LW'(limit_i[cur_q]);
    if (lim_raw == '0) begin
      lim_eff = LW'(1);
    end else if (lim_raw > LW'(QUEUE_DEPTH)) begin
      lim_eff = LW'(QUEUE_DEPTH);
    end else begin
      lim_eff = lim_raw;
    end
  end
  assign at_limit = LW'(n) >= lim_eff;

  // Identifier comparator on the registered read data
  assign hit = rdv_q && (rd_data_q == ev_q);

  // Shared slot adder: (head + offset) mod depth, then queue base
  assign slot_sum = {1'b0, h} + (PW+1)'(off);
  assign slot     = (slot_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                    PW'(slot_sum - (PW+1)'(QUEUE_DEPTH)) : slot_sum[PW-1:0];
  assign addr     = AW'(cur_ix * QUEUE_DEPTH) + AW'(slot);

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (start_i) st_d = S_LOAD;
      end
      S_LOAD: begin
        if (is_bcast) begin
          st_d = cur_pres ? S_SCAN : S_NEXT;
        end else if (!cur_pres) begin
          st_d = S_DONE;
        end else begin
          case (func_q)
            FUNC_PUSH: st_d = S_SCAN;
            FUNC_POP:  st_d = (n == '0) ? S_DONE : S_POP_RD;
            default:   st_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          st_d = is_bcast ? S_NEXT : S_DONE;
        end else if ((idx_q == n) && !rdv_q) begin
          st_d = S_WRITE;
        end
      end
      S_WRITE: begin
        st_d = is_bcast ? S_NEXT : S_DONE;
      end
      S_NEXT: begin
        st_d = (cur_q == QidxW'(NQE - 1)) ? S_DONE : S_LOAD;
      end
      S_POP_RD: begin
        st_d = S_POP_DATA;
      end
      S_POP_DATA: begin
        st_d = S_DONE;
      end
      S_DONE: begin
        if (ack_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    status_d = status_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    off      = '0;
    case (st_q)
      S_LOAD: begin
        if (!is_bcast && !cur_pres) begin
          status_d = STAT_NOQ;
        end else if (!is_bcast && (func_q == FUNC_POP) && (n == '0)) begin
          status_d = STAT_EMPTY;
        end
      end
      S_SCAN: begin
        off   = idx_q;
        rd_en = !hit && (idx_q < n);
        if (hit && !is_bcast) status_d = STAT_DUP;
      end
      S_WRITE: begin
        off   = n;
        wr_en = 1'b1;
      end
      S_POP_RD: begin
        rd_en = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      rdv_q <= 1'b0;
      for (int q = 0; q < NQE; q++) begin
        head_q[q] <= '0;
        cnt_q[q]  <= '0;
      end
    end else begin
      st_q  <= st_d;
      rdv_q <= (st_q == S_SCAN) && rd_en;
      if ((st_q == S_WRITE) && !at_limit) begin
        cnt_q[cur_ix] <= n + 1'b1;
      end else if (st_q == S_WRITE) begin
        head_q[cur_ix] <= h_inc;
      end
      if (st_q == S_POP_DATA) begin
        head_q[cur_ix] <= h_inc;
        cnt_q[cur_ix]  <= n - 1'b1;
      end
      // Empty a queue whose present bit flips
      for (int q = 0; q < NQE; q++) begin
        if (clr_i[q]) begin
          head_q[q] <= '0;
          cnt_q[q]  <= '0;
        end
      end
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if ((st_q == S_IDLE) && start_i) begin
      func_q   <= req_i.func;
      qidx_q   <= req_i.qidx;
      bcast_q  <= req_i.bcast;
      ev_q     <= event_i;
      evo_q    <= '0;
      status_q <= STAT_DONE;
      cur_q    <= ((req_i.func == FUNC_PUSH) && req_i.bcast) ? '0 : req_i.qidx;
    end else begin
      status_q <= status_d;
      if (st_q == S_NEXT) cur_q <= cur_q + 1'b1;
      if (st_q == S_POP_DATA) evo_q <= rd_data_q;
    end
    if (st_q == S_LOAD) begin
      idx_q <= '0;
    end else if ((st_q == S_SCAN) && rd_en) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Entry memory: one port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[addr] <= ev_q;
    if (rd_en) rd_data_q <= mem[addr];
  end

  assign resp_o.idle   = (st_q == S_IDLE);
  assign resp_o.done   = (st_q == S_DONE);
  assign resp_o.status = status_q;
  assign event_o       = evo_q;
  assign count_o       = pres(qidx_q, mask_i) ? cnt_q[qidx_q[QW-1:0]] : '0;

endmodule

// ===== rtl/core/multi_queue_dedup_event_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// multi_queue_dedup_event_fifo_unit
// Small FIFO queues of event identifiers with duplicate refusal and
// drop-oldest on a full queue. Push, pop and size query, one result per item.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    func, queue_index, broadcast, event_in
//   out      output     out_valid_o / out_stall_i  status, event_out, queue_count,
//                                                  queues_present
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Push: the scan reads one entry a cycle, and a duplicate ends it early.
// Broadcast push visits every queue in turn and, in each present one, scans and
// appends unless it finds a duplicate. Pop reads the head entry; size query,
// empty pop or absent queue go straight to the result. Then the sequencer idles.
// Reset empties every queue and sets all limits to 16; no clearing pass.
// The input stalls while busy; a full output register holds the sequencer.
// ----------------------------------------------------------------------------
module multi_queue_dedup_event_fifo_unit import mqdef_pkg::*; #(
  parameter int unsigned NUM_QUEUES  = NumQueuesDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned EVENT_WIDTH = EventWidthDef,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Item input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [QidxW-1:0]       queue_index_i,
  input  logic                   broadcast_i,
  input  logic [EVENT_WIDTH-1:0] event_in_i,
  // Result output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [EVENT_WIDTH-1:0] event_out_o,
  output logic [CW-1:0]          queue_count_o,
  output logic [PresW-1:0]       queues_present_o,
  // Configuration writes
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  logic [MaxQueues-1:0]             mask_q;
  logic [MaxQueues-1:0][LimitW-1:0] limit_q;
  logic [MaxQueues-1:0]             clr;
  logic [MaxQueues-1:0]             changed;

  mqdef_req_t             req;
  mqdef_resp_t            resp;
  logic [EVENT_WIDTH-1:0] eng_event;
  logic [CW-1:0]          eng_count;
  logic                   start;
  logic                   ack;
  logic                   load;
  logic [PresW-1:0]       npres;

  logic                   out_valid_q;
  status_e                status_q;
  logic [EVENT_WIDTH-1:0] event_out_q;
  logic [CW-1:0]          count_q;
  logic [PresW-1:0]       npres_q;

  // Accept an item only while the sequencer is idle
  assign in_stall_o = !resp.idle;
  assign start      = in_valid_i && !in_stall_o;
  assign req.func   = func_e'(func_i);
  assign req.qidx   = queue_index_i;
  assign req.bcast  = broadcast_i;

  // Clear queues whose present bit flips
  assign changed = cfg_data_i[MaxQueues-1:0] ^ mask_q;
  always_comb begin
    clr = '0;
    if (cfg_we_i && (reg_idx_e'(cfg_idx_i) == REG_PRESENT_MASK)) begin
      for (int q = 0; q < MaxQueues; q++) begin
        clr[q] = changed[q] && (q < int'(NUM_QUEUES));
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      for (int q = 0; q < MaxQueues; q++) begin
        limit_q[q] <= LimitReset;
      end
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PRESENT_MASK: mask_q     <= cfg_data_i[MaxQueues-1:0];
        REG_LIMIT_Q0:     limit_q[0] <= cfg_data_i[LimitW-1:0];
        REG_LIMIT_Q1:     limit_q[1] <= cfg_data_i[LimitW-1:0];
        REG_LIMIT_Q2:     limit_q[2] <= cfg_data_i[LimitW-1:0];
        REG_LIMIT_Q3:     limit_q[3] <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Count present queues
  always_comb begin
    npres = '0;
    for (int q = 0; q < MaxQueues; q++) begin
      if (mask_q[q] && (q < int'(NUM_QUEUES))) npres = npres + 1'b1;
    end
  end

  mqdef_engine #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .EVENT_WIDTH (EVENT_WIDTH)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req),
    .event_i (event_in_i),
    .mask_i  (mask_q),
    .limit_i (limit_q),
    .clr_i   (clr),
    .ack_i   (ack),
    .resp_o  (resp),
    .event_o (eng_event),
    .count_o (eng_count)
  );

  // Output register: load when empty or being drained
  assign ack  = !out_valid_q || !out_stall_i;
  assign load = resp.done && ack;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q    <= resp.status;
      event_out_q <= eng_event;
      count_q     <= eng_count;
      npres_q     <= npres;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign event_out_o      = event_out_q;
  assign queue_count_o    = count_q;
  assign queues_present_o = npres_q;

endmodule
